// ----- rtl/pid_position_controller_with_exit_top_macros.svh -----
// Assertion macros for the PID position controller.
// Included by the RTL files that carry concurrent checks; clocked on clk, reset rst_n.
`ifndef PID_POSITION_CONTROLLER_WITH_EXIT_TOP_MACROS_SVH
`define PID_POSITION_CONTROLLER_WITH_EXIT_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PIDPC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PIDPC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pidpc_pkg.sv -----
// Shared types and constants for the PID position controller.
// No dependencies; imported by every RTL module of the block.
package pidpc_pkg;

    // Register field widths
    localparam int GAIN_W  = 24;
    localparam int THR_W   = 24;
    localparam int CNT_W   = 16;
    localparam int MAXD_W  = 15;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 3;
    localparam int DRIVE_W = 16;
    localparam int INT_W   = 32;
    localparam int USER_W  = 3;

    // Default parameter values
    localparam int POS_BITS_DEF       = 24;
    localparam int GAIN_FRAC_BITS_DEF = 16;

    localparam logic [MAXD_W-1:0] MAX_DRIVE_RST = 15'd12000;
    localparam logic [CNT_W-1:0]  CNT_MAX       = 16'hFFFF;
    localparam logic [INT_W-1:0]  INT_POS_MAX   = 32'h7FFF_FFFF;
    localparam logic [INT_W-1:0]  INT_NEG_MAX   = 32'h8000_0000;

    // Command carried in tuser
    typedef enum logic {
        CMD_NEW  = 1'b0,
        CMD_CONT = 1'b1
    } cmd_t;

    // Reason a move ended
    typedef enum logic [1:0] {
        CAUSE_RUN     = 2'd0,
        CAUSE_SETTLED = 2'd1,
        CAUSE_STALLED = 2'd2
    } cause_t;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_GAIN_P      = 3'd0,
        REG_GAIN_I      = 3'd1,
        REG_GAIN_D      = 3'd2,
        REG_SETTLE_THR  = 3'd3,
        REG_SETTLE_CNT  = 3'd4,
        REG_STALL_THR   = 3'd5,
        REG_STALL_CNT   = 3'd6,
        REG_MAX_DRIVE   = 3'd7
    } cfg_idx_t;

    // Status that travels with each word down the datapath
    typedef struct packed {
        logic   finished;
        cause_t cause;
    } pidpc_ctl_t;

endpackage

// ----- rtl/pid_position_controller_with_exit_top.sv -----
// PID position controller with settle and stall exit: a word passes the input, result,
// product, sum and output registers; throughput is one word per cycle while the output
// takes words, set by the front-stage state update and the registered multiplies.
// Every stage holds its word under back pressure and a free stage keeps taking words.
// rst_n clears all valid bits and the move state; max_drive resets to 12000, other
// registers to zero. Depends on pidpc_pkg, pidpc_front, pidpc_mac and pidpc_clamp.
module pid_position_controller_with_exit_top #(
    parameter int POS_BITS       = pidpc_pkg::POS_BITS_DEF,
    parameter int GAIN_FRAC_BITS = pidpc_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Configuration write port
    input  logic                                   cfg_we,
    input  logic [pidpc_pkg::IDX_W-1:0]            cfg_addr,
    input  logic [pidpc_pkg::CFG_W-1:0]            cfg_data,
    // Input stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata: measured_position, target_position, zero fill
    input  logic [((2*POS_BITS+7)/8)*8-1:0]        s_axis_tdata,
    // tuser: cmd
    input  logic                                   s_axis_tuser,
    // Output stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // tdata: drive
    output logic [pidpc_pkg::DRIVE_W-1:0]          m_axis_tdata,
    // tuser: finished, exit_cause
    output logic [pidpc_pkg::USER_W-1:0]           m_axis_tuser
);
    import pidpc_pkg::*;

    localparam int SUM_W = 2 + (((25 + POS_BITS + 2) > 57) ? (25 + POS_BITS + 2) : 57);

    // Configuration registers
    logic [GAIN_W-1:0]  gain_p_reg;
    logic [GAIN_W-1:0]  gain_i_reg;
    logic [GAIN_W-1:0]  gain_d_reg;
    logic [THR_W-1:0]   settle_thr_reg;
    logic [CNT_W-1:0]   settle_cnt_reg;
    logic [THR_W-1:0]   stall_thr_reg;
    logic [CNT_W-1:0]   stall_cnt_reg;
    logic [MAXD_W-1:0]  max_drive_reg;

    logic                       f_valid;
    logic                       f_ready;
    logic signed [POS_BITS:0]   f_err;
    logic signed [POS_BITS+1:0] f_der;
    logic signed [INT_W-1:0]    f_int;
    pidpc_ctl_t                 f_ctl;

    logic                       m_valid;
    logic                       m_ready;
    logic signed [SUM_W-1:0]    m_sum;
    pidpc_ctl_t                 m_ctl;

    logic signed [DRIVE_W-1:0]  drive;
    logic                       finished;
    cause_t                     exit_cause;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg     <= '0;
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
            settle_thr_reg <= '0;
            settle_cnt_reg <= '0;
            stall_thr_reg  <= '0;
            stall_cnt_reg  <= '0;
            max_drive_reg  <= MAX_DRIVE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                REG_GAIN_P:     gain_p_reg     <= cfg_data[GAIN_W-1:0];
                REG_GAIN_I:     gain_i_reg     <= cfg_data[GAIN_W-1:0];
                REG_GAIN_D:     gain_d_reg     <= cfg_data[GAIN_W-1:0];
                REG_SETTLE_THR: settle_thr_reg <= cfg_data[THR_W-1:0];
                REG_SETTLE_CNT: settle_cnt_reg <= cfg_data[CNT_W-1:0];
                REG_STALL_THR:  stall_thr_reg  <= cfg_data[THR_W-1:0];
                REG_STALL_CNT:  stall_cnt_reg  <= cfg_data[CNT_W-1:0];
                REG_MAX_DRIVE:  max_drive_reg  <= cfg_data[MAXD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Input register and move state
    pidpc_front #(
        .POS_BITS (POS_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_cmd     (cmd_t'(s_axis_tuser)),
        .in_meas    (signed'(s_axis_tdata[POS_BITS-1:0])),
        .in_tgt     (signed'(s_axis_tdata[2*POS_BITS-1:POS_BITS])),
        .gain_i     (gain_i_reg),
        .settle_thr (settle_thr_reg),
        .settle_cnt (settle_cnt_reg),
        .stall_thr  (stall_thr_reg),
        .stall_cnt  (stall_cnt_reg),
        .out_valid  (f_valid),
        .out_ready  (f_ready),
        .out_err    (f_err),
        .out_der    (f_der),
        .out_int    (f_int),
        .out_ctl    (f_ctl)
    );

    // Multiplies and sum
    pidpc_mac #(
        .POS_BITS (POS_BITS),
        .SUM_W    (SUM_W)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_err    (f_err),
        .in_der    (f_der),
        .in_int    (f_int),
        .in_ctl    (f_ctl),
        .gain_p    (gain_p_reg),
        .gain_i    (gain_i_reg),
        .gain_d    (gain_d_reg),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_sum   (m_sum),
        .out_ctl   (m_ctl)
    );

    // Truncation, clamp and output register
    pidpc_clamp #(
        .SUM_W          (SUM_W),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_clamp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (m_valid),
        .in_ready     (m_ready),
        .in_sum       (m_sum),
        .in_ctl       (m_ctl),
        .max_drive    (max_drive_reg),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_drive    (drive),
        .out_finished (finished),
        .out_cause    (exit_cause)
    );

    assign m_axis_tdata = unsigned'(drive);
    assign m_axis_tuser = {exit_cause, finished};

endmodule

// ----- rtl/pidpc_front.sv -----
// Input register, move state and error/derivative/integral update.
// Depends on pidpc_pkg and the assertion macro header.
`include "pid_position_controller_with_exit_top_macros.svh"

module pidpc_front #(
    parameter int POS_BITS = pidpc_pkg::POS_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  pidpc_pkg::cmd_t                     in_cmd,
    input  logic signed [POS_BITS-1:0]          in_meas,
    input  logic signed [POS_BITS-1:0]          in_tgt,
    input  logic [pidpc_pkg::GAIN_W-1:0]        gain_i,
    input  logic [pidpc_pkg::THR_W-1:0]         settle_thr,
    input  logic [pidpc_pkg::CNT_W-1:0]         settle_cnt,
    input  logic [pidpc_pkg::THR_W-1:0]         stall_thr,
    input  logic [pidpc_pkg::CNT_W-1:0]         stall_cnt,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [POS_BITS:0]            out_err,
    output logic signed [POS_BITS+1:0]          out_der,
    output logic signed [pidpc_pkg::INT_W-1:0]  out_int,
    output pidpc_pkg::pidpc_ctl_t               out_ctl
);
    import pidpc_pkg::*;

    localparam int E_W   = POS_BITS + 1;
    localparam int D_W   = POS_BITS + 2;
    localparam int CMP_W = (D_W > THR_W) ? D_W : THR_W;
    localparam int IA_W  = ((E_W > INT_W) ? E_W : INT_W) + 1;

    // Input register stage
    logic                       a_valid_reg;
    cmd_t                       a_cmd_reg;
    logic signed [POS_BITS-1:0] a_meas_reg;
    logic signed [POS_BITS-1:0] a_tgt_reg;

    // Move state
    logic signed [E_W-1:0]      last_err_reg;
    logic signed [INT_W-1:0]    integ_reg;
    logic [CNT_W-1:0]           set_cnt_reg;
    logic [CNT_W-1:0]           stl_cnt_reg;
    logic                       done_reg;
    cause_t                     cause_reg;

    // Result register stage
    logic                       b_valid_reg;
    logic signed [E_W-1:0]      b_err_reg;
    logic signed [D_W-1:0]      b_der_reg;
    logic signed [INT_W-1:0]    b_int_reg;
    pidpc_ctl_t                 b_ctl_reg;

    logic                       b_ready;
    logic                       fire;
    logic                       new_move;
    logic signed [E_W-1:0]      eff_last;
    logic signed [INT_W-1:0]    eff_int;
    logic [CNT_W-1:0]           eff_set;
    logic [CNT_W-1:0]           eff_stl;
    logic                       eff_done;
    logic signed [E_W-1:0]      err;
    logic signed [D_W-1:0]      der;
    logic [E_W-1:0]             mag_err;
    logic [D_W-1:0]             mag_der;
    logic signed [IA_W-1:0]     ia_sum;
    logic [IA_W-32:0]           ia_hi;
    logic signed [INT_W-1:0]    int_sat;
    logic signed [INT_W-1:0]    int_add;
    logic                       sign_diff;
    logic signed [INT_W-1:0]    int_next;
    logic [CNT_W-1:0]           set_next;
    logic [CNT_W-1:0]           stl_next;
    logic                       settle_exit;
    logic                       stall_exit;
    logic                       stl_hit;
    pidpc_ctl_t                 ctl_next;

    // Handshake: each stage takes a word when it is empty or its word moves on
    assign b_ready  = !b_valid_reg || out_ready;
    assign in_ready = !a_valid_reg || b_ready;
    assign fire     = a_valid_reg && b_ready;

    // A new move sees cleared state
    always_comb
    begin
        new_move = (a_cmd_reg == CMD_NEW);
        eff_last = new_move ? '0 : last_err_reg;
        eff_int  = new_move ? '0 : integ_reg;
        eff_set  = new_move ? '0 : set_cnt_reg;
        eff_stl  = new_move ? '0 : stl_cnt_reg;
        eff_done = new_move ? 1'b0 : done_reg;
    end

    // Error, derivative and their magnitudes
    always_comb
    begin
        err     = E_W'(a_tgt_reg) - E_W'(a_meas_reg);
        der     = D_W'(err) - D_W'(eff_last);
        mag_err = err[E_W-1] ? unsigned'(-err) : unsigned'(err);
        mag_der = der[D_W-1] ? unsigned'(-der) : unsigned'(der);
    end

    // Saturating integral, cleared on a change of error sign
    always_comb
    begin
        ia_sum    = IA_W'(eff_int) + IA_W'(err);
        ia_hi     = ia_sum[IA_W-1:INT_W-1];
        if ((&ia_hi) || !(|ia_hi))
            int_sat = ia_sum[INT_W-1:0];
        else
            int_sat = ia_sum[IA_W-1] ? INT_NEG_MAX : INT_POS_MAX;
        int_add   = (gain_i != '0) ? int_sat : eff_int;
        sign_diff = ((err == '0) != (eff_last == '0)) || (err[E_W-1] != eff_last[E_W-1]);
        int_next  = sign_diff ? '0 : int_add;
    end

    // Settle and stall counters; settling is checked first
    always_comb
    begin
        if (CMP_W'(mag_err) < CMP_W'(settle_thr))
            set_next = (eff_set == CNT_MAX) ? eff_set : eff_set + 1'b1;
        else
            set_next = '0;
        settle_exit = (set_next >= settle_cnt);
        stl_hit     = (CMP_W'(mag_der) < CMP_W'(stall_thr)) && (eff_stl != CNT_MAX);
        if (settle_exit)
            stl_next = eff_stl;
        else
            stl_next = stl_hit ? eff_stl + 1'b1 : eff_stl;
        stall_exit  = !settle_exit && (stl_next > stall_cnt);

        if (eff_done)
        begin
            ctl_next.finished = 1'b1;
            ctl_next.cause    = cause_reg;
        end
        else if (settle_exit)
        begin
            ctl_next.finished = 1'b1;
            ctl_next.cause    = CAUSE_SETTLED;
        end
        else if (stall_exit)
        begin
            ctl_next.finished = 1'b1;
            ctl_next.cause    = CAUSE_STALLED;
        end
        else
        begin
            ctl_next.finished = 1'b0;
            ctl_next.cause    = CAUSE_RUN;
        end
    end

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (in_ready)
            a_valid_reg <= in_valid;
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            a_cmd_reg  <= in_cmd;
            a_meas_reg <= in_meas;
            a_tgt_reg  <= in_tgt;
        end
    end

    // Move state: updated as a word leaves the input register while the move is not finished
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_err_reg <= '0;
            integ_reg    <= '0;
            set_cnt_reg  <= '0;
            stl_cnt_reg  <= '0;
            done_reg     <= 1'b0;
            cause_reg    <= CAUSE_RUN;
        end
        else if (fire && !eff_done)
        begin
            last_err_reg <= err;
            integ_reg    <= int_next;
            set_cnt_reg  <= set_next;
            stl_cnt_reg  <= stl_next;
            done_reg     <= ctl_next.finished;
            cause_reg    <= ctl_next.cause;
        end
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (b_ready)
            b_valid_reg <= a_valid_reg;
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            b_err_reg <= err;
            b_der_reg <= der;
            b_int_reg <= int_next;
            b_ctl_reg <= ctl_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_err   = b_err_reg;
    assign out_der   = b_der_reg;
    assign out_int   = b_int_reg;
    assign out_ctl   = b_ctl_reg;

    // Checks
    `PIDPC_ASSERT_IMP(a_done_cause, 1'b1, done_reg == (cause_reg != CAUSE_RUN), "cause disagrees with done")
    `PIDPC_ASSERT_IMP(a_done_src, $rose(done_reg), $past(fire), "move ended without a word")
    `PIDPC_ASSERT_IMP(a_ctl_pair, b_valid_reg, b_ctl_reg.finished == (b_ctl_reg.cause != CAUSE_RUN), "bad status word")
    `PIDPC_ASSERT_NXT(a_hold_state, fire && eff_done, $stable(last_err_reg) && $stable(integ_reg), "state moved after finish")

endmodule

// ----- rtl/pidpc_mac.sv -----
// Gain multiplies and product sum, two register stages.
// Depends on pidpc_pkg.
module pidpc_mac #(
    parameter int POS_BITS = pidpc_pkg::POS_BITS_DEF,
    parameter int SUM_W    = 2 + (((25 + POS_BITS + 2) > 57) ? (25 + POS_BITS + 2) : 57)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [POS_BITS:0]            in_err,
    input  logic signed [POS_BITS+1:0]          in_der,
    input  logic signed [pidpc_pkg::INT_W-1:0]  in_int,
    input  pidpc_pkg::pidpc_ctl_t               in_ctl,
    input  logic [pidpc_pkg::GAIN_W-1:0]        gain_p,
    input  logic [pidpc_pkg::GAIN_W-1:0]        gain_i,
    input  logic [pidpc_pkg::GAIN_W-1:0]        gain_d,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [SUM_W-1:0]             out_sum,
    output pidpc_pkg::pidpc_ctl_t               out_ctl
);
    import pidpc_pkg::*;

    localparam int G_W = GAIN_W + 1;
    localparam int P_W = G_W + POS_BITS + 1;
    localparam int I_W = G_W + INT_W;
    localparam int D_W = G_W + POS_BITS + 2;

    logic                   c_valid_reg;
    logic signed [P_W-1:0]  p_reg;
    logic signed [I_W-1:0]  i_reg;
    logic signed [D_W-1:0]  d_reg;
    pidpc_ctl_t             c_ctl_reg;

    logic                   s_valid_reg;
    logic signed [SUM_W-1:0] sum_reg;
    pidpc_ctl_t             s_ctl_reg;

    logic                   s_ready;
    logic                   c_ready;
    logic signed [G_W-1:0]  gp_s;
    logic signed [G_W-1:0]  gi_s;
    logic signed [G_W-1:0]  gd_s;
    logic signed [SUM_W-1:0] sum_next;

    assign s_ready  = !s_valid_reg || out_ready;
    assign c_ready  = !c_valid_reg || s_ready;
    assign in_ready = c_ready;

    // Gains are unsigned; a zero sign bit makes them signed operands
    assign gp_s = signed'({1'b0, gain_p});
    assign gi_s = signed'({1'b0, gain_i});
    assign gd_s = signed'({1'b0, gain_d});

    assign sum_next = SUM_W'(p_reg) + SUM_W'(i_reg) + SUM_W'(d_reg);

    // Product stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (c_ready)
            c_valid_reg <= in_valid;
    end

    // Product stage: three parallel multiplies
    always_ff @(posedge clk)
    begin
        if (c_ready && in_valid)
        begin
            p_reg     <= gp_s * in_err;
            i_reg     <= gi_s * in_int;
            d_reg     <= gd_s * in_der;
            c_ctl_reg <= in_ctl;
        end
    end

    // Sum stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_valid_reg <= 1'b0;
        else if (s_ready)
            s_valid_reg <= c_valid_reg;
    end

    // Sum stage
    always_ff @(posedge clk)
    begin
        if (s_ready && c_valid_reg)
        begin
            sum_reg   <= sum_next;
            s_ctl_reg <= c_ctl_reg;
        end
    end

    assign out_valid = s_valid_reg;
    assign out_sum   = sum_reg;
    assign out_ctl   = s_ctl_reg;

endmodule

// ----- rtl/pidpc_clamp.sv -----
// Fixed-point truncation toward zero, drive clamp and output register.
// Depends on pidpc_pkg and the assertion macro header.
`include "pid_position_controller_with_exit_top_macros.svh"

module pidpc_clamp #(
    parameter int SUM_W          = 60,
    parameter int GAIN_FRAC_BITS = pidpc_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [SUM_W-1:0]             in_sum,
    input  pidpc_pkg::pidpc_ctl_t               in_ctl,
    input  logic [pidpc_pkg::MAXD_W-1:0]        max_drive,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [pidpc_pkg::DRIVE_W-1:0] out_drive,
    output logic                                out_finished,
    output pidpc_pkg::cause_t                   out_cause
);
    import pidpc_pkg::*;

    logic                       out_valid_reg;
    logic signed [DRIVE_W-1:0]  drive_reg;
    logic                       fin_reg;
    cause_t                     cause_reg;

    logic [SUM_W-1:0]           mag;
    logic [SUM_W-1:0]           quot;
    logic [DRIVE_W-1:0]         drive_abs;
    logic signed [DRIVE_W-1:0]  drive_next;
    logic signed [DRIVE_W-1:0]  lim_s;

    assign in_ready = !out_valid_reg || out_ready;
    assign lim_s    = signed'({1'b0, max_drive});

    // Truncate the magnitude, clamp, then restore the sign; a finished word drives zero
    always_comb
    begin
        mag  = in_sum[SUM_W-1] ? unsigned'(-in_sum) : unsigned'(in_sum);
        quot = mag >> GAIN_FRAC_BITS;
        if (quot >= SUM_W'(max_drive))
            drive_abs = DRIVE_W'(max_drive);
        else
            drive_abs = quot[DRIVE_W-1:0];
        if (in_ctl.finished)
            drive_next = '0;
        else if (in_sum[SUM_W-1])
            drive_next = -signed'(drive_abs);
        else
            drive_next = signed'(drive_abs);
    end

    // Output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ready)
            out_valid_reg <= in_valid;
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            drive_reg <= drive_next;
            fin_reg   <= in_ctl.finished;
            cause_reg <= in_ctl.cause;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_drive    = drive_reg;
    assign out_finished = fin_reg;
    assign out_cause    = cause_reg;

    // Checks
    `PIDPC_ASSERT_IMP(a_drive_lim, out_valid_reg, (drive_reg <= lim_s) && (drive_reg >= -lim_s), "drive beyond limit")
    `PIDPC_ASSERT_IMP(a_fin_zero, out_valid_reg && fin_reg, drive_reg == '0, "drive not zero after finish")

endmodule

// ----- verif/pidpc_drive_checker.sv -----
// Checker for the PID position controller: follows register writes, predicts one drive
// word per accepted sample and compares it with each word the block sends out.
// Depends on pidpc_pkg; instantiated beside the block by pid_position_controller_with_exit_top_tb.
module pidpc_drive_checker #(
    parameter int POS_BITS       = pidpc_pkg::POS_BITS_DEF,
    parameter int GAIN_FRAC_BITS = pidpc_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [pidpc_pkg::IDX_W-1:0]            cfg_addr,
    input  logic [pidpc_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                   s_axis_tvalid,
    input  logic                                   s_axis_tready,
    // tdata: measured_position, target_position, zero fill
    input  logic [((2*POS_BITS+7)/8)*8-1:0]        s_axis_tdata,
    // tuser: cmd
    input  logic                                   s_axis_tuser,
    input  logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // tdata: drive
    input  logic [pidpc_pkg::DRIVE_W-1:0]          m_axis_tdata,
    // tuser: finished, exit_cause
    input  logic [pidpc_pkg::USER_W-1:0]           m_axis_tuser,
    output int unsigned                            outstanding,
    output int unsigned                            fail_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import pidpc_pkg::*;

    localparam longint INTEG_HI = longint'($signed(INT_POS_MAX));
    localparam longint INTEG_LO = longint'($signed(INT_NEG_MAX));
    localparam int     MAX_REPORTS = 40;

    typedef struct {
        logic signed [DRIVE_W-1:0] drive;
        logic                      finished;
        cause_t                    cause;
    } drive_word_t;

    // Local copy of the register file.
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [THR_W-1:0]  settle_thr;
    logic [CNT_W-1:0]  settle_need;
    logic [THR_W-1:0]  stall_thr;
    logic [CNT_W-1:0]  stall_limit;
    logic [MAXD_W-1:0] drive_lim;

    // Move state of the controller.
    longint            last_err;
    longint            integ;
    int unsigned       settled_cnt;
    int unsigned       stalled_cnt;
    logic              move_over;
    cause_t            held_cause;

    drive_word_t       expected_drive_q[$];

    function automatic int direction(input longint x);
        return (x > 0) ? 1 : ((x < 0) ? -1 : 0);
    endfunction

    function automatic longint magnitude(input longint x);
        return (x < 0) ? -x : x;
    endfunction

    task automatic clear_move();
        last_err    = 0;
        integ       = 0;
        settled_cnt = 0;
        stalled_cnt = 0;
        move_over   = 1'b0;
        held_cause  = CAUSE_RUN;
    endtask

    task automatic report_mismatch(input string msg);
        if (fail_count < MAX_REPORTS)
            $display("%0t: drive word error: %s", $realtime, msg);
        fail_count++;
    endtask

    // Work out the drive word that one accepted sample must produce.
    task automatic predict_drive(input logic cmd_bit,
                                 input logic signed [POS_BITS-1:0] meas,
                                 input logic signed [POS_BITS-1:0] targ);
        longint      err;
        longint      der;
        longint      total;
        longint      scaled;
        longint      drv;
        longint      lim;
        drive_word_t word;
        if (cmd_t'(cmd_bit) == CMD_NEW)
            clear_move();
        if (!move_over)
        begin
            err = longint'(targ) - longint'(meas);
            der = err - last_err;
            // The integral only accumulates while the integral gain is nonzero.
            if (gain_i != '0)
            begin
                integ = integ + err;
                if (integ > INTEG_HI)
                    integ = INTEG_HI;
                if (integ < INTEG_LO)
                    integ = INTEG_LO;
            end
            // Any change in the direction of the error restarts the integral.
            if (direction(err) != direction(last_err))
                integ = 0;
            total = longint'(gain_p) * err + longint'(gain_i) * integ
                  + longint'(gain_d) * der;
            // Truncate toward zero, then clamp symmetrically.
            scaled = magnitude(total) >> GAIN_FRAC_BITS;
            drv    = (total < 0) ? -scaled : scaled;
            lim    = longint'(drive_lim);
            if (drv >= lim)
                drv = lim;
            if (drv <= -lim)
                drv = -lim;
            last_err = err;
            // Settling is checked first; the stall count never clears within a move.
            if (magnitude(err) < longint'(settle_thr))
            begin
                if (settled_cnt < CNT_MAX)
                    settled_cnt++;
            end
            else
                settled_cnt = 0;
            if (settled_cnt >= settle_need)
            begin
                move_over  = 1'b1;
                held_cause = CAUSE_SETTLED;
            end
            else
            begin
                if (magnitude(der) < longint'(stall_thr) && stalled_cnt < CNT_MAX)
                    stalled_cnt++;
                if (stalled_cnt > stall_limit)
                begin
                    move_over  = 1'b1;
                    held_cause = CAUSE_STALLED;
                end
            end
        end
        if (move_over)
        begin
            word.drive    = '0;
            word.finished = 1'b1;
            word.cause    = held_cause;
        end
        else
        begin
            word.drive    = drv[DRIVE_W-1:0];
            word.finished = 1'b0;
            word.cause    = CAUSE_RUN;
        end
        expected_drive_q.push_back(word);
    endtask

    // Compare one output word with the oldest prediction.
    task automatic check_drive();
        drive_word_t want;
        if (expected_drive_q.size() == 0)
            report_mismatch($sformatf("unexpected word, drive %0d finished %b cause %0d",
                                      $signed(m_axis_tdata), m_axis_tuser[0],
                                      m_axis_tuser[2:1]));
        else
        begin
            want = expected_drive_q.pop_front();
            if (m_axis_tdata !== want.drive || m_axis_tuser[0] !== want.finished
                || m_axis_tuser[2:1] !== want.cause)
                report_mismatch($sformatf("drive %0d want %0d, finished %b want %b, cause %0d want %0d",
                                          $signed(m_axis_tdata), want.drive,
                                          m_axis_tuser[0], want.finished,
                                          m_axis_tuser[2:1], want.cause));
        end
    endtask

    // Everything is sampled at the rising edge, before the drivers update.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p      = '0;
            gain_i      = '0;
            gain_d      = '0;
            settle_thr  = '0;
            settle_need = '0;
            stall_thr   = '0;
            stall_limit = '0;
            drive_lim   = MAX_DRIVE_RST;
            clear_move();
            expected_drive_q.delete();
            fail_count  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_addr))
                    REG_GAIN_P:     gain_p      = cfg_data[GAIN_W-1:0];
                    REG_GAIN_I:     gain_i      = cfg_data[GAIN_W-1:0];
                    REG_GAIN_D:     gain_d      = cfg_data[GAIN_W-1:0];
                    REG_SETTLE_THR: settle_thr  = cfg_data[THR_W-1:0];
                    REG_SETTLE_CNT: settle_need = cfg_data[CNT_W-1:0];
                    REG_STALL_THR:  stall_thr   = cfg_data[THR_W-1:0];
                    REG_STALL_CNT:  stall_limit = cfg_data[CNT_W-1:0];
                    REG_MAX_DRIVE:  drive_lim   = cfg_data[MAXD_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_drive(s_axis_tuser, s_axis_tdata[POS_BITS-1:0],
                              s_axis_tdata[2*POS_BITS-1:POS_BITS]);
            if (m_axis_tvalid && m_axis_tready)
                check_drive();
            outstanding <= expected_drive_q.size();
        end
    end

endmodule

// ----- verif/pid_position_controller_with_exit_top_tb.sv -----
// Top of the PID position controller testbench: clock, reset, register setup, sample
// stimulus, output back pressure and the final verdict.
// Depends on pidpc_pkg, pidpc_drive_checker and the block pid_position_controller_with_exit_top.
module pid_position_controller_with_exit_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pidpc_pkg::*;

    localparam int POS_W        = POS_BITS_DEF;
    localparam int TDATA_W      = ((2 * POS_W + 7) / 8) * 8;
    localparam int POS_HI       = (1 << (POS_W - 1)) - 1;
    localparam int POS_LO       = -(1 << (POS_W - 1));
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_RUN     = 20;

    localparam logic [GAIN_W-1:0] GAIN_FULL  = '1;
    localparam logic [THR_W-1:0]  THR_FULL   = '1;
    localparam logic [CNT_W-1:0]  CNT_FULL   = '1;
    localparam logic [MAXD_W-1:0] DRIVE_FULL = '1;

    typedef struct {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [THR_W-1:0]  settle_thr;
        logic [CNT_W-1:0]  settle_need;
        logic [THR_W-1:0]  stall_thr;
        logic [CNT_W-1:0]  stall_limit;
        logic [MAXD_W-1:0] drive_lim;
    } loop_setting_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [IDX_W-1:0]     cfg_addr      = '0;
    logic [CFG_W-1:0]     cfg_data      = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                 s_axis_tuser  = CMD_CONT;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [DRIVE_W-1:0]   m_axis_tdata;
    logic [USER_W-1:0]    m_axis_tuser;
    int unsigned          outstanding;
    int unsigned          fail_count;
    int                   tx_idle_pct   = 0;
    int                   rx_idle_pct   = 0;

    pid_position_controller_with_exit_top i_dut (.*);

    pidpc_drive_checker i_checker (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Output back pressure.
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

    // Hard stop in case the block hangs.
    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int rand_pos();
        return int'($urandom) >>> (32 - POS_W);
    endfunction

    function automatic int clamp_pos(input int p);
        return (p > POS_HI) ? POS_HI : ((p < POS_LO) ? POS_LO : p);
    endfunction

    function automatic loop_setting_t random_setting();
        loop_setting_t cfg;
        cfg.gain_p      = GAIN_W'($urandom_range(24'h04_0000));
        cfg.gain_i      = ($urandom_range(2) == 0) ? '0
                                                   : GAIN_W'($urandom_range(24'h00_2000, 1));
        cfg.gain_d      = GAIN_W'($urandom_range(24'h08_0000));
        cfg.settle_thr  = THR_W'($urandom_range(400, 1));
        cfg.settle_need = CNT_W'($urandom_range(6, 1));
        cfg.stall_thr   = THR_W'($urandom_range(8));
        cfg.stall_limit = CNT_W'($urandom_range(12, 2));
        cfg.drive_lim   = MAXD_W'($urandom_range(32767));
        return cfg;
    endfunction

    // Offer one sample word and hold it until the block takes it.
    task automatic send_word(input cmd_t cmd, input int meas, input int targ);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= TDATA_W'({targ[POS_W-1:0], meas[POS_W-1:0]});
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Stop sending and wait until every predicted word has come out.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(input loop_setting_t cfg);
        wait_idle();
        write_reg(REG_GAIN_P, cfg.gain_p);
        write_reg(REG_GAIN_I, cfg.gain_i);
        write_reg(REG_GAIN_D, cfg.gain_d);
        write_reg(REG_SETTLE_THR, cfg.settle_thr);
        write_reg(REG_SETTLE_CNT, CFG_W'(cfg.settle_need));
        write_reg(REG_STALL_THR, cfg.stall_thr);
        write_reg(REG_STALL_CNT, CFG_W'(cfg.stall_limit));
        write_reg(REG_MAX_DRIVE, CFG_W'(cfg.drive_lim));
    endtask

    // Start a move and keep feeding the same sample.
    task automatic repeat_sample(input int meas, input int targ, input int count);
        send_word(CMD_NEW, meas, targ);
        repeat (count) send_word(CMD_CONT, meas, targ);
    endtask

    // Mostly whole moves against a simple plant that closes in on the target,
    // sometimes sticks, and jitters; the rest are random words.
    task automatic run_moves(input int count);
        int sent;
        int pos;
        int tgt;
        int steps;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(99) < 20)
            begin
                send_word(cmd_t'($urandom_range(1)), int'($urandom), int'($urandom));
                sent++;
            end
            else
            begin
                tgt = rand_pos();
                if ($urandom_range(1) == 1)
                    pos = rand_pos();
                else
                    pos = clamp_pos(tgt + int'($urandom_range(2000)) - 1000);
                steps = $urandom_range(40, 3);
                send_word(CMD_NEW, pos, tgt);
                sent++;
                while (steps > 0 && sent < count)
                begin
                    if ($urandom_range(99) >= 15)
                        pos = clamp_pos(pos + (tgt - pos) / int'($urandom_range(3, 1))
                                        + int'($urandom_range(6)) - 3);
                    send_word(CMD_CONT, pos, tgt);
                    sent++;
                    steps--;
                end
            end
        end
    endtask

    initial
    begin
        loop_setting_t cfg;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed samples: extremes, exits, holding after an exit, exit priority.
        cfg = '{24'h01_0000, 24'h00_0100, 24'h00_8000, 24'd50, 16'd3, 24'd2, 16'd3,
                15'd12000};
        apply_setting(cfg);
        send_word(CMD_NEW, 0, 0);
        send_word(CMD_NEW, POS_LO, POS_HI);
        send_word(CMD_CONT, POS_HI, POS_LO);
        send_word(CMD_CONT, POS_HI, POS_LO);
        send_word(CMD_CONT, -1, -1);
        send_word(CMD_NEW, 100, 120);
        send_word(CMD_CONT, 110, 120);
        send_word(CMD_CONT, 119, 120);
        send_word(CMD_CONT, POS_LO, POS_HI);
        repeat_sample(0, 10000, 5);
        // The stall count is ready to trip on the same word that settles the move.
        repeat_sample(0, 1000, 3);
        send_word(CMD_CONT, 0, 1);
        send_word(CMD_CONT, 0, 40);
        send_word(CMD_CONT, 0, 41);

        for (int mode = 0; mode < 3; mode++)
        begin
            wait_idle();
            case (mode)
                0:
                begin
                    tx_idle_pct = 27;
                    rx_idle_pct <= 52;
                end
                1:
                begin
                    tx_idle_pct = 52;
                    rx_idle_pct <= 27;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                end
            endcase
            apply_setting(random_setting());
            run_moves(15);
            apply_setting(random_setting());
            run_moves(15);
            case (mode)
                0:
                begin
                    // Full gains drive the integral into saturation both ways.
                    cfg = '{GAIN_FULL, GAIN_FULL, GAIN_FULL, 24'd0, CNT_FULL, 24'd0, CNT_FULL,
                            DRIVE_FULL};
                    apply_setting(cfg);
                    repeat_sample(POS_LO, POS_HI, 132);
                    repeat_sample(POS_HI, POS_LO, 132);
                    run_moves(10);
                end
                1:
                begin
                    // No drive allowed, then every move settling on its first word.
                    cfg = random_setting();
                    cfg.drive_lim = '0;
                    apply_setting(cfg);
                    run_moves(10);
                    cfg = '{24'd0, 24'd0, 24'd0, 24'd0, 16'd0, 24'd0, 16'd0, 15'd12000};
                    apply_setting(cfg);
                    run_moves(10);
                end
                default:
                begin
                    // A stall limit at the counter ceiling keeps a stalled move running.
                    cfg = '{24'h01_0000, 24'h00_0100, 24'd0, 24'd0, CNT_FULL, THR_FULL,
                            CNT_FULL, DRIVE_FULL};
                    apply_setting(cfg);
                    repeat_sample(0, 500, HOLD_RUN);
                    // A long settle count keeps a settled move running.
                    cfg = '{24'h00_4000, 24'd0, 24'h00_4000, THR_FULL, CNT_FULL, 24'd0,
                            16'd0, DRIVE_FULL};
                    apply_setting(cfg);
                    repeat_sample(0, 500, HOLD_RUN);
                end
            endcase
        end

        wait_idle();
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
